// ===== sv/improved_noise_3d_top_assert.svh =====
// assertion macros for the improved noise block
`ifndef IMPROVED_NOISE_3D_TOP_ASSERT_SVH
`define IMPROVED_NOISE_3D_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define IN3_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define IN3_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/in3_pkg.sv =====
// package with shared types, commands and configuration register indexes
package in3_pkg;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;
  localparam int OUT_W = 18;

  // configuration register indexes
  localparam logic [1:0] REG_OFF_X = 2'd0;
  localparam logic [1:0] REG_OFF_Y = 2'd1;
  localparam logic [1:0] REG_OFF_Z = 2'd2;

  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic       re;
    logic [7:0] raddr;
  } in3_mem_req_t;
endpackage

// ===== sv/in3_perm_mem.sv =====
// permutation table memory, one write and one read per cycle, registered read
module in3_perm_mem
  import in3_pkg::*;
(
  input  logic         clk,
  input  in3_mem_req_t req,
  output logic [7:0]   rdata
);
  logic [7:0] mem [256];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end
endmodule

// ===== sv/in3_core.sv =====
// evaluation sequencer: split, fade, hash lookups, gradients and blends
module in3_core
  import in3_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [31:0]    cx_in,
  input  logic signed [31:0]    cy_in,
  input  logic signed [31:0]    cz_in,
  input  logic [23:0]           off_x,
  input  logic [23:0]           off_y,
  input  logic [23:0]           off_z,
  output in3_mem_req_t          mreq,
  input  logic [7:0]            mrdata,
  output logic                  done,
  output logic signed [OUT_W-1:0] result
);
  localparam int FW = FRAC_BITS;
  localparam int VW = FW + 8;
  localparam logic [FW:0] ONE = (FW+1)'(1) << FW;
  localparam logic signed [2*VW-1:0] HALF = (2*VW)'(1) << (FW - 1);

  localparam logic [4:0] S_IDLE = 5'd0, S_FADE = 5'd1, S_RA = 5'd2, S_RB = 5'd3,
    S_RA1 = 5'd4, S_RB1 = 5'd5, S_RAA = 5'd6, S_RAB = 5'd7, S_RBA = 5'd8, S_RBB = 5'd9,
    S_C0 = 5'd10, S_BL = 5'd18, S_OUT = 5'd19;

  logic [4:0]  st_r, st_nxt;
  logic [3:0]  k_r;
  logic [7:0]  cel_r [3];
  logic [FW-1:0] fr_r [3];
  logic [FW:0] fd_r [3];
  logic [7:0]  a_r, b_r, aa_r, ab_r, ba_r, bb_r;
  logic signed [VW-1:0] g_r [8];
  logic signed [VW-1:0] acc_r;
  logic [1:0]  fs_r;
  logic [2:0]  fstep_r;
  logic [FW+4:0] t2_r, t3_r, inn_r;
  logic [7:0]  hidx;
  logic [2:0]  cidx;

  // one multiplier shared for fade steps and blends
  logic signed [VW:0]     pa;
  logic signed [FW+5:0]   pb;
  logic signed [2*VW-1:0] prod, prnd;
  logic signed [2*VW-1:0] pshift;

  assign prod = pa * pb;
  assign prnd = prod + HALF;
  assign pshift = prnd >>> FW;

  function automatic logic signed [VW-1:0] grad(input logic [3:0] h,
      input logic signed [VW-1:0] x, input logic signed [VW-1:0] y,
      input logic signed [VW-1:0] z);
    logic signed [VW-1:0] u, v;
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  logic [31:0] sx, sy, sz;
  assign sx = cx_in + {8'd0, off_x};
  assign sy = cy_in + {8'd0, off_y};
  assign sz = cz_in + {8'd0, off_z};

  // corner k: bit2 = x, bit1 = y, bit0 = z; hash address per corner
  always_comb begin
    cidx = k_r[2:0];
    case (cidx[2:1])
      2'd0: hidx = aa_r;
      2'd1: hidx = ab_r;
      2'd2: hidx = ba_r;
      default: hidx = bb_r;
    endcase
    hidx = hidx + {7'd0, cidx[0]};
  end

  // blend schedule operands
  logic signed [VW-1:0] bl_a, bl_b;
  logic [FW:0] bl_t;
  always_comb begin
    case (k_r[2:0])
      3'd0: begin bl_a = g_r[0]; bl_b = g_r[4]; bl_t = fd_r[0]; end
      3'd1: begin bl_a = g_r[2]; bl_b = g_r[6]; bl_t = fd_r[0]; end
      3'd2: begin bl_a = g_r[1]; bl_b = g_r[5]; bl_t = fd_r[0]; end
      3'd3: begin bl_a = g_r[3]; bl_b = g_r[7]; bl_t = fd_r[0]; end
      3'd4: begin bl_a = g_r[0]; bl_b = g_r[2]; bl_t = fd_r[1]; end
      3'd5: begin bl_a = g_r[1]; bl_b = g_r[3]; bl_t = fd_r[1]; end
      default: begin bl_a = g_r[0]; bl_b = g_r[1]; bl_t = fd_r[2]; end
    endcase
  end

  logic [FW+4:0] fcoef;
  always_comb begin
    pa = '0;
    pb = '0;
    fcoef = '0;
    if (st_r == S_FADE) begin
      case (fstep_r)
        3'd0: begin
          fcoef = (FW+5)'(15) * (FW+5)'(ONE) - (FW+5)'(6) * (FW+5)'(fr_r[fs_r]);
          pa = (VW+1)'(fr_r[fs_r]); pb = (FW+6)'(fcoef);
        end
        3'd1: begin pa = (VW+1)'(fr_r[fs_r]); pb = (FW+6)'(fr_r[fs_r]); end
        3'd2: begin pa = (VW+1)'(t2_r); pb = (FW+6)'(fr_r[fs_r]); end
        default: begin
          pa = (VW+1)'(t3_r);
          pb = (FW+6)'((FW+5)'(10) * (FW+5)'(ONE) - inn_r);
        end
      endcase
    end else begin
      pa = (VW+1)'(bl_b - bl_a);
      pb = (FW+6)'(bl_t);
    end
  end

  // hash reads: cx, cx+1, a, a+1, b, b+1, each used the cycle after it is issued
  always_comb begin
    st_nxt = st_r;
    mreq = '0;
    case (st_r)
      S_IDLE: if (start) st_nxt = S_FADE;
      S_FADE: if (fs_r == 2'd2 && fstep_r == 3'd3) begin
        st_nxt = S_RA; mreq.re = 1'b1; mreq.raddr = cel_r[0];
      end
      S_RA: begin st_nxt = S_RB; mreq.re = 1'b1; mreq.raddr = cel_r[0] + 8'd1; end
      S_RB: begin st_nxt = S_RA1; mreq.re = 1'b1; mreq.raddr = a_r; end
      S_RA1: begin st_nxt = S_RB1; mreq.re = 1'b1; mreq.raddr = a_r + 8'd1; end
      S_RB1: begin st_nxt = S_RAA; mreq.re = 1'b1; mreq.raddr = b_r; end
      S_RAA: begin st_nxt = S_RAB; mreq.re = 1'b1; mreq.raddr = b_r + 8'd1; end
      S_RAB: st_nxt = S_RBA;
      S_RBA: st_nxt = S_RBB;
      S_RBB: begin st_nxt = S_C0; mreq.re = 1'b1; mreq.raddr = aa_r; end
      S_C0: begin
        mreq.re = 1'b1;
        mreq.raddr = hidx;
        if (k_r == 4'd8) st_nxt = S_BL;
      end
      S_BL: if (k_r[2:0] == 3'd6) st_nxt = S_OUT;
      S_OUT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  logic signed [VW-1:0] cx0, cx1, cy0, cy1, cz0, cz1, gnew;
  logic [2:0] pk;
  assign pk = k_r[2:0] - 3'd1;
  assign cx0 = VW'(fr_r[0]);
  assign cy0 = VW'(fr_r[1]);
  assign cz0 = VW'(fr_r[2]);
  assign cx1 = cx0 - VW'(ONE);
  assign cy1 = cy0 - VW'(ONE);
  assign cz1 = cz0 - VW'(ONE);
  assign gnew = grad(mrdata[3:0], pk[2] ? cx1 : cx0, pk[1] ? cy1 : cy0,
                     pk[0] ? cz1 : cz0);

  logic signed [VW-1:0] blv;
  assign blv = bl_a + VW'(pshift);

  // output rounding/saturation
  logic signed [VW+8:0] rs;
  always_comb begin
    if (FW > 16) rs = (VW+9)'((acc_r + VW'(1 << (FW - 17))) >>> (FW - 16));
    else rs = (VW+9)'(acc_r) <<< (16 - FW);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      done <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done <= (st_r == S_OUT);
    end
  end

  logic [FW+4:0] fres;
  assign fres = (FW+5)'(pshift);

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        cel_r[0] <= sx[FW+7:FW]; fr_r[0] <= sx[FW-1:0];
        cel_r[1] <= sy[FW+7:FW]; fr_r[1] <= sy[FW-1:0];
        cel_r[2] <= sz[FW+7:FW]; fr_r[2] <= sz[FW-1:0];
        fs_r <= 2'd0; fstep_r <= 3'd0; k_r <= 4'd0;
      end
      S_FADE: begin
        case (fstep_r)
          3'd0: inn_r <= fres;
          3'd1: t2_r <= fres;
          3'd2: t3_r <= fres;
          default: fd_r[fs_r] <= (fres > (FW+5)'(ONE)) ? ONE : fres[FW:0];
        endcase
        if (fstep_r == 3'd3) begin
          fstep_r <= 3'd0; fs_r <= fs_r + 2'd1;
        end else begin
          fstep_r <= fstep_r + 3'd1;
        end
      end
      S_RA: a_r <= mrdata + cel_r[1];
      S_RB: b_r <= mrdata + cel_r[1];
      S_RA1: aa_r <= mrdata + cel_r[2];
      S_RB1: ab_r <= mrdata + cel_r[2];
      S_RAA: ba_r <= mrdata + cel_r[2];
      S_RAB: bb_r <= mrdata + cel_r[2];
      S_RBB: k_r <= 4'd1;
      S_C0: begin
        g_r[pk] <= gnew;
        k_r <= (k_r == 4'd8) ? 4'd0 : k_r + 4'd1;
      end
      S_BL: begin
        case (k_r[2:0])
          3'd0: g_r[0] <= blv;
          3'd1: g_r[2] <= blv;
          3'd2: g_r[1] <= blv;
          3'd3: g_r[3] <= blv;
          3'd4: g_r[0] <= blv;
          3'd5: g_r[1] <= blv;
          default: acc_r <= blv;
        endcase
        k_r <= k_r + 4'd1;
      end
      S_OUT: begin
        if (rs > (VW+9)'(131071)) result <= 18'sd131071;
        else if (rs < -(VW+9)'(131072)) result <= -18'sd131072;
        else result <= rs[OUT_W-1:0];
      end
      default: ;
    endcase
  end
endmodule

// ===== sv/improved_noise_3d_top.sv =====
// top level of the 3d improved noise evaluator
//
//  channel | dir | tdata fields (low bit up)                         | tuser
//  in_     | in  | table_index, table_value, coord_x, coord_y, coord_z | cmd
//  out_    | out | noise_value                                        | -
//  cfg_    | in  | offset_x, offset_y, offset_z by index               | -
//
// a load word is one write into the permutation memory
// an evaluate word runs 12 fade multiplies on the shared multiplier, 6 dependent
// hash reads and 8 corner reads through the single memory read port, 7 blends,
// then rounding
// reset is synchronous, active low; the table is undefined until loaded
// the result sits in an output register; a stalled out_ side holds it and
// the next word is not taken until it leaves
module improved_noise_3d_top
  import in3_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,  // table_index, table_value, coord_x, coord_y, coord_z
  input  logic         in_tuser,  // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata, // noise_value
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_wdata
);
  logic [23:0] off_x_r, off_y_r, off_z_r;
  logic        busy_r;
  logic        ov_r;
  logic signed [OUT_W-1:0] res_r;
  in3_mem_req_t creq, mreq;
  logic [7:0]  mrdata;
  logic        cdone, start, acc;
  logic signed [OUT_W-1:0] cres;

  assign in_tready = !busy_r && !ov_r;
  assign acc = in_tvalid && in_tready;
  assign start = acc && (in_tuser == CMD_EVAL);

  // load words write straight into the table
  always_comb begin
    mreq = creq;
    if (acc && in_tuser == CMD_LOAD) begin
      mreq.we = 1'b1;
      mreq.waddr = in_tdata[7:0];
      mreq.wdata = in_tdata[15:8];
    end
  end

  in3_perm_mem u_mem (.clk(clk), .req(mreq), .rdata(mrdata));

  in3_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk(clk), .rst_n(rst_n), .start(start),
    .cx_in(in_tdata[47:16]), .cy_in(in_tdata[79:48]), .cz_in(in_tdata[111:80]),
    .off_x(off_x_r), .off_y(off_y_r), .off_z(off_z_r),
    .mreq(creq), .mrdata(mrdata), .done(cdone), .result(cres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0; off_y_r <= '0; off_z_r <= '0;
      busy_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OFF_X: off_x_r <= cfg_wdata;
          REG_OFF_Y: off_y_r <= cfg_wdata;
          REG_OFF_Z: off_z_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (start) busy_r <= 1'b1;
      if (cdone) begin
        busy_r <= 1'b0; ov_r <= 1'b1; res_r <= cres;
      end else if (ov_r && out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {{(24-OUT_W){1'b0}}, res_r};
endmodule

// ===== sv/improved_noise_3d_top_chk.sv =====
// port checker for the noise block, bound to the top level
module improved_noise_3d_top_chk (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic in_tuser,
  input logic out_tvalid,
  input logic out_tready,
  input logic [23:0] out_tdata
);
`include "improved_noise_3d_top_assert.svh"
  `IN3_ASSERT_IMP(a_no_in_while_out, out_tvalid, !in_tready)
  `IN3_ASSERT_NXT(a_eval_blocks, in_tvalid && in_tready && in_tuser, !in_tready)
  `IN3_ASSERT_NXT(a_out_holds, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `IN3_ASSERT_NXT(a_load_no_out, in_tvalid && in_tready && !in_tuser, !out_tvalid)
endmodule

bind improved_noise_3d_top improved_noise_3d_top_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
